/* rtl/ofit_pkg.sv */
// shared types and character codes of the obj face index triangulator
`default_nettype none

package ofit_pkg;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VTAB  = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;

	typedef enum logic [6:0] {
		K_START = 7'b0000001,
		K_V1    = 7'b0000010,
		K_VERT  = 7'b0000100,
		K_TEX   = 7'b0001000,
		K_FHEAD = 7'b0010000,
		K_FACE  = 7'b0100000,
		K_OTHER = 7'b1000000
	} kind_t;

	typedef enum logic [1:0] {
		ROLE_ANCHOR,
		ROLE_PREV,
		ROLE_EMIT
	} role_t;

	typedef struct packed {
		role_t role;
		logic  neg_pos;
		logic  neg_tex;
		logic  has_tex;
	} corner_ctl_t;

	typedef struct packed {
		logic [15:0] pos;
		logic [15:0] tex;
		logic        tex_ok;
		logic        err;
	} corner_t;

endpackage

`default_nettype wire

/* rtl/ofit_if.sv */
// valid/ready channel interfaces for text bytes and triangles
`default_nettype none

interface ofit_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, text_byte, last_byte, input ready);
	modport sink (input valid, text_byte, last_byte, output ready);
endinterface

interface ofit_tri_if;
	logic        valid;
	logic        ready;
	logic [15:0] pos_a;
	logic [15:0] pos_b;
	logic [15:0] pos_c;
	logic [15:0] tex_a;
	logic [15:0] tex_b;
	logic [15:0] tex_c;
	logic [2:0]  tex_present;
	logic        index_error;

	modport source (output valid, pos_a, pos_b, pos_c, tex_a, tex_b, tex_c,
		tex_present, index_error, input ready);
	modport sink (input valid, pos_a, pos_b, pos_c, tex_a, tex_b, tex_c,
		tex_present, index_error, output ready);
endinterface

`default_nettype wire

/* rtl/ofit_front.sv */
// front end: line classification, vertex and texture counting and corner field parsing
`default_nettype none

module ofit_front #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ofit_text_if.sink                        text,
	input  wire logic                        ev_full,
	output logic                             ev_push,
	output ofit_pkg::corner_ctl_t            ev_ctl,
	output logic [4*(INDEX_BITS+1)-1:0]      ev_data
);
	import ofit_pkg::*;

	localparam int MW = INDEX_BITS + 1;
	localparam logic [MW-1:0] LIM = {1'b1, {INDEX_BITS{1'b0}}};

	kind_t           kind_q, kind_d;
	logic [MW-1:0]   vcnt_q, vcnt_d, tcnt_q, tcnt_d;
	logic [1:0]      fn_q, fn_d, cc_q, cc_d;
	logic [MW-1:0]   mag_q, mag_d, rpos_q, rpos_d, rtex_q, rtex_d;
	logic            neg_q, neg_d, rpos_neg_q, rpos_neg_d, rtex_neg_q, rtex_neg_d;
	logic            started_q, started_d, stopped_q, stopped_d, topen_q, topen_d;
	logic            acc, close, line_end;
	logic [7:0]      c;
	logic [MW+3:0]   sum;
	logic [MW-1:0]   ev_pos, ev_tex;

	assign c   = text.text_byte;
	assign acc = text.valid && text.ready;
	assign sum = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + (MW+4)'(c[3:0]);
	assign text.ready = !ev_full;
	assign ev_push = close;
	assign ev_data = {ev_pos, ev_tex, vcnt_q, tcnt_q};

	always_comb begin
		kind_d     = kind_q;
		vcnt_d     = vcnt_q;
		tcnt_d     = tcnt_q;
		fn_d       = fn_q;
		cc_d       = cc_q;
		mag_d      = mag_q;
		neg_d      = neg_q;
		started_d  = started_q;
		stopped_d  = stopped_q;
		topen_d    = topen_q;
		rpos_d     = rpos_q;
		rpos_neg_d = rpos_neg_q;
		rtex_d     = rtex_q;
		rtex_neg_d = rtex_neg_q;
		close      = 1'b0;
		line_end   = 1'b0;
		if (acc) begin
			if (c == CH_NL) begin
				close    = (kind_q == K_FACE) && topen_q;
				line_end = 1'b1;
			end else begin
				unique case (kind_q)
					K_START: begin
						if (c == CH_V)
							kind_d = K_V1;
						else if (c == CH_F)
							kind_d = K_FHEAD;
						else
							kind_d = K_OTHER;
					end
					K_V1: begin
						if (c == CH_SPACE) begin
							kind_d = K_VERT;
							if (vcnt_q != LIM)
								vcnt_d = vcnt_q + MW'(1);
						end else if (c == CH_T) begin
							kind_d = K_TEX;
							if (tcnt_q != LIM)
								tcnt_d = tcnt_q + MW'(1);
						end else begin
							kind_d = K_OTHER;
						end
					end
					K_FHEAD: begin
						if (c == CH_SPACE)
							kind_d = K_FACE;
					end
					K_FACE: begin
						if (c == CH_SPACE) begin
							close = topen_q;
						end else if (c == CH_SLASH) begin
							topen_d = 1'b1;
							if (fn_q == 2'd0) begin
								rpos_d     = mag_q;
								rpos_neg_d = neg_q;
							end
							if (fn_q == 2'd1) begin
								rtex_d     = mag_q;
								rtex_neg_d = neg_q;
							end
							if (fn_q != 2'd3)
								fn_d = fn_q + 2'd1;
							mag_d     = '0;
							neg_d     = 1'b0;
							started_d = 1'b0;
							stopped_d = 1'b0;
						end else begin
							topen_d = 1'b1;
							if (!stopped_q) begin
								if (c >= CH_ZERO && c <= CH_NINE) begin
									mag_d     = (sum > (MW+4)'(LIM)) ? LIM : sum[MW-1:0];
									started_d = 1'b1;
								end else if (!started_q && (c == CH_TAB || c == CH_VTAB ||
										c == CH_FF || c == CH_CR)) begin
									started_d = 1'b0;
								end else if (!started_q && (c == CH_PLUS || c == CH_MINUS)) begin
									neg_d     = (c == CH_MINUS);
									started_d = 1'b1;
								end else begin
									stopped_d = 1'b1;
								end
							end
						end
					end
					K_VERT, K_TEX, K_OTHER: begin
						kind_d = kind_q;
					end
					default: begin
						kind_d = K_START;
					end
				endcase
				if (text.last_byte) begin
					if (kind_d == K_FACE && topen_d)
						close = 1'b1;
					line_end = 1'b1;
				end
			end
		end

		// closing field: the pending number lands in its field slot
		ev_ctl.has_tex = (fn_d != 2'd0);
		ev_pos         = (fn_d == 2'd0) ? mag_d : rpos_d;
		ev_ctl.neg_pos = (fn_d == 2'd0) ? neg_d : rpos_neg_d;
		ev_tex         = (fn_d == 2'd1) ? mag_d : rtex_d;
		ev_ctl.neg_tex = (fn_d == 2'd1) ? neg_d : rtex_neg_d;
		if (cc_q == 2'd0)
			ev_ctl.role = ROLE_ANCHOR;
		else if (cc_q == 2'd1)
			ev_ctl.role = ROLE_PREV;
		else
			ev_ctl.role = ROLE_EMIT;

		if (close)
			cc_d = (cc_q == 2'd0) ? 2'd1 : 2'd2;
		if (line_end) begin
			kind_d = K_START;
			cc_d   = 2'd0;
		end
		if (close || line_end) begin
			fn_d       = 2'd0;
			mag_d      = '0;
			neg_d      = 1'b0;
			started_d  = 1'b0;
			stopped_d  = 1'b0;
			topen_d    = 1'b0;
			rpos_d     = '0;
			rpos_neg_d = 1'b0;
			rtex_d     = '0;
			rtex_neg_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= K_START;
			vcnt_q     <= '0;
			tcnt_q     <= '0;
			fn_q       <= 2'd0;
			cc_q       <= 2'd0;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			started_q  <= 1'b0;
			stopped_q  <= 1'b0;
			topen_q    <= 1'b0;
			rpos_q     <= '0;
			rpos_neg_q <= 1'b0;
			rtex_q     <= '0;
			rtex_neg_q <= 1'b0;
		end else begin
			kind_q     <= kind_d;
			vcnt_q     <= vcnt_d;
			tcnt_q     <= tcnt_d;
			fn_q       <= fn_d;
			cc_q       <= cc_d;
			mag_q      <= mag_d;
			neg_q      <= neg_d;
			started_q  <= started_d;
			stopped_q  <= stopped_d;
			topen_q    <= topen_d;
			rpos_q     <= rpos_d;
			rpos_neg_q <= rpos_neg_d;
			rtex_q     <= rtex_d;
			rtex_neg_q <= rtex_neg_d;
		end
	end

`ifndef ASSERT_OFF
	a_close_in_face: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push |-> kind_q == K_FACE)
		else $error("corner closed outside a face line");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= LIM && tcnt_q <= LIM)
		else $error("vertex or texture count beyond saturation");
`endif

endmodule

`default_nettype wire

/* rtl/ofit_queue.sv */
// small register queue between the parser and the resolver
`default_nettype none

module ofit_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      dout
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/ofit_back.sv */
// back end: index resolution, fan corner tracking and triangle output register
`default_nettype none

module ofit_back #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         ev_valid,
	input  wire ofit_pkg::corner_ctl_t        ev_ctl,
	input  wire logic [4*(INDEX_BITS+1)-1:0]  ev_data,
	output logic                              ev_pop,
	ofit_tri_if.source                        faces
);
	import ofit_pkg::*;

	localparam int MW = INDEX_BITS + 1;

	logic [MW-1:0] mag_pos, mag_tex, vcnt, tcnt;
	logic [17:0]   rp, rt;
	corner_t       cur;
	corner_t       anchor_q, prev_q, oa_q, ob_q, oc_q;
	logic          emit, out_valid_q;

	// returns {in range, resolves to minus one, index}
	function automatic logic [17:0] resolve(input logic [MW-1:0] mag, input logic neg,
			input logic [MW-1:0] cnt);
		logic          ok, m1;
		logic [MW-1:0] idx;
		logic [MW:0]   cnt_p1;
		cnt_p1 = {1'b0, cnt} + (MW+1)'(1);
		if (neg && mag != '0) begin
			ok  = (mag <= cnt);
			idx = cnt - mag;
			m1  = ({1'b0, mag} == cnt_p1);
		end else begin
			ok  = (mag != '0) && (mag <= cnt);
			idx = mag - MW'(1);
			m1  = (mag == '0);
		end
		return {ok, m1, 16'(idx)};
	endfunction

	assign {mag_pos, mag_tex, vcnt, tcnt} = ev_data;
	assign rp = resolve(mag_pos, ev_ctl.neg_pos, vcnt);
	assign rt = resolve(mag_tex, ev_ctl.neg_tex, tcnt);

	always_comb begin
		cur.pos    = rp[17] ? rp[15:0] : 16'd0;
		cur.tex_ok = ev_ctl.has_tex && rt[17];
		cur.tex    = cur.tex_ok ? rt[15:0] : 16'd0;
		cur.err    = !rp[17] || (ev_ctl.has_tex && !rt[17] && !rt[16]);
	end

	assign emit   = (ev_ctl.role == ROLE_EMIT);
	assign ev_pop = ev_valid && (!emit || !out_valid_q || faces.ready);

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			case (ev_ctl.role)
				ROLE_ANCHOR: anchor_q <= cur;
				ROLE_PREV:   prev_q   <= cur;
				ROLE_EMIT: begin
					oa_q   <= anchor_q;
					ob_q   <= prev_q;
					oc_q   <= cur;
					prev_q <= cur;
				end
				default: prev_q <= cur;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ev_pop && emit)
			out_valid_q <= 1'b1;
		else if (faces.ready)
			out_valid_q <= 1'b0;
	end

	assign faces.valid       = out_valid_q;
	assign faces.pos_a       = oa_q.pos;
	assign faces.pos_b       = ob_q.pos;
	assign faces.pos_c       = oc_q.pos;
	assign faces.tex_a       = oa_q.tex;
	assign faces.tex_b       = ob_q.tex;
	assign faces.tex_c       = oc_q.tex;
	assign faces.tex_present = {oc_q.tex_ok, ob_q.tex_ok, oa_q.tex_ok};
	assign faces.index_error = oa_q.err || ob_q.err || oc_q.err;

`ifndef ASSERT_OFF
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ev_pop && emit |=> faces.valid)
		else $error("triangle popped but not presented");
`endif

endmodule

`default_nettype wire

/* rtl/obj_face_index_triangulator_core.sv */
// top level of the obj face index triangulator
//
// text: one byte of obj text per item, last_byte closes the final line.
// faces: one item per fan triangle (anchor, previous, current corner) with
//   resolved 0-based position and texture indices, texture flags and an
//   index error flag.
// throughput: one text byte per cycle while the corner queue is not full and one triangle
//   per cycle while faces is ready; a corner closes at most once per byte, so the parser never outruns the resolver
// path: the edge that takes the byte closing a corner writes it into the corner queue;
//   the resolver then loads its triangle into the output register that drives faces,
//   behind any corners queued ahead of it
// the parser and the resolver are parted by a four-entry corner queue; when
//   faces stalls, the output register holds its item, the resolver stops at
//   the next triangle and text.ready drops only once the queue is full
// reset: asynchronous, clears line state, vertex and texture counts and the
//   queue; the block takes bytes in the first cycle after reset
//
`default_nettype none

module obj_face_index_triangulator_core #(
	parameter int INDEX_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ofit_text_if.sink  text,
	ofit_tri_if.source faces
);
	import ofit_pkg::*;

	localparam int DW     = 4 * (INDEX_BITS + 1);
	localparam int CW     = $bits(corner_ctl_t);
	localparam int QDEPTH = 4;

	logic              ev_push, ev_full, ev_pop, ev_valid;
	corner_ctl_t       push_ctl, pop_ctl;
	logic [DW-1:0]     push_data, pop_data;

	ofit_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.ev_full (ev_full),
		.ev_push (ev_push),
		.ev_ctl  (push_ctl),
		.ev_data (push_data)
	);

	ofit_queue #(.WIDTH(CW + DW), .DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.din    ({push_ctl, push_data}),
		.full   (ev_full),
		.pop    (ev_pop),
		.valid  (ev_valid),
		.dout   ({pop_ctl, pop_data})
	);

	ofit_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_ctl   (pop_ctl),
		.ev_data  (pop_data),
		.ev_pop   (ev_pop),
		.faces    (faces)
	);

endmodule

`default_nettype wire

/* tb/obj_face_index_triangulator_core_test.sv */
// self-checking testbench: obj text bytes in, predicted fan triangles compared item by item
`default_nettype none

module obj_face_index_triangulator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ofit_pkg::*;

	localparam int INDEX_BITS  = 16;
	localparam int INDEX_LIMIT = 1 << INDEX_BITS;
	localparam int CLK_PERIOD  = 4;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_BYTES = 650;
	localparam int STALL_CORNERS = 30;
	localparam int TAIL_BYTES = 150;
	localparam int CYCLE_LIMIT = 2000000;

	typedef logic [7:0] text_t[$];

	typedef struct packed {
		logic [15:0] pos_a;
		logic [15:0] pos_b;
		logic [15:0] pos_c;
		logic [15:0] tex_a;
		logic [15:0] tex_b;
		logic [15:0] tex_c;
		logic [2:0]  tex_present;
		logic        index_error;
	} tri_t;

	logic clk = 1'b0;
	logic arst_n;

	ofit_text_if text_ch();
	ofit_tri_if  tri_ch();

	obj_face_index_triangulator_core #(
		.INDEX_BITS(INDEX_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.faces(tri_ch)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// parser state
	kind_t   line_state = K_START;
	int      vert_total = 0;
	int      tex_total = 0;
	int      field_idx = 0;
	int      num_mag = 0;
	bit      num_neg = 1'b0;
	bit      num_begun = 1'b0;
	bit      num_done = 1'b0;
	bit      token_live = 1'b0;
	int      corners_in_line = 0;
	int      raw_pos_val = 0;
	int      raw_tex_val = 0;
	corner_t anchor_seen = '0;
	corner_t prev_seen = '0;

	tri_t triangles_due[$];

	int  mismatch_count = 0;
	int  bytes_sent = 0;
	int  cycle_count = 0;
	bit  sender_idle = 1'b1;
	bit  receiver_idle = 1'b1;
	int  hold_ticket = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	int  ready_gap = 0;

	function automatic void reset_number();
		num_mag = 0;
		num_neg = 1'b0;
		num_begun = 1'b0;
		num_done = 1'b0;
	endfunction

	function automatic void reset_token();
		reset_number();
		field_idx = 0;
		raw_pos_val = 0;
		raw_tex_val = 0;
		token_live = 1'b0;
	endfunction

	function automatic void finish_line();
		line_state = K_START;
		corners_in_line = 0;
		reset_token();
	endfunction

	function automatic void feed_digit(logic [7:0] c);
		if (num_done)
			return;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			num_mag = num_mag * 10 + int'(c - CH_ZERO);
			if (num_mag > INDEX_LIMIT)
				num_mag = INDEX_LIMIT;
			num_begun = 1'b1;
		end else if (!num_begun && (c == CH_TAB || c == CH_VTAB || c == CH_FF || c == CH_CR)) begin
		end else if (!num_begun && (c == CH_PLUS || c == CH_MINUS)) begin
			num_neg = (c == CH_MINUS);
			num_begun = 1'b1;
		end else begin
			num_done = 1'b1;
		end
	endfunction

	function automatic void finish_field();
		int v;
		v = num_neg ? -num_mag : num_mag;
		if (field_idx == 0)
			raw_pos_val = v;
		else if (field_idx == 1)
			raw_tex_val = v;
		if (field_idx < 3)
			field_idx++;
		reset_number();
	endfunction

	function automatic int resolve_index(int v, int cnt);
		return (v < 0) ? cnt + v : v - 1;
	endfunction

	function automatic void close_corner();
		corner_t c;
		tri_t    tri_item;
		int      p;
		int      t;
		finish_field();
		c = '0;
		p = resolve_index(raw_pos_val, vert_total);
		if (p >= 0 && p < vert_total)
			c.pos = p[15:0];
		else
			c.err = 1'b1;
		if (field_idx >= 2) begin
			t = resolve_index(raw_tex_val, tex_total);
			if (t >= 0 && t < tex_total) begin
				c.tex = t[15:0];
				c.tex_ok = 1'b1;
			end else if (t != -1) begin
				c.err = 1'b1;
			end
		end
		if (corners_in_line == 0) begin
			anchor_seen = c;
			corners_in_line = 1;
		end else if (corners_in_line == 1) begin
			prev_seen = c;
			corners_in_line = 2;
		end else begin
			tri_item.pos_a = anchor_seen.pos;
			tri_item.pos_b = prev_seen.pos;
			tri_item.pos_c = c.pos;
			tri_item.tex_a = anchor_seen.tex;
			tri_item.tex_b = prev_seen.tex;
			tri_item.tex_c = c.tex;
			tri_item.tex_present = {c.tex_ok, prev_seen.tex_ok, anchor_seen.tex_ok};
			tri_item.index_error = anchor_seen.err | prev_seen.err | c.err;
			triangles_due = {triangles_due, tri_item};
			prev_seen = c;
		end
		reset_token();
	endfunction

	function automatic void parse_text_byte(logic [7:0] c, logic last);
		if (c == CH_NL) begin
			if (line_state == K_FACE && token_live)
				close_corner();
			finish_line();
			return;
		end
		case (line_state)
			K_START: begin
				if (c == CH_V)
					line_state = K_V1;
				else if (c == CH_F)
					line_state = K_FHEAD;
				else
					line_state = K_OTHER;
			end
			K_V1: begin
				if (c == CH_SPACE) begin
					line_state = K_VERT;
					if (vert_total < INDEX_LIMIT)
						vert_total++;
				end else if (c == CH_T) begin
					line_state = K_TEX;
					if (tex_total < INDEX_LIMIT)
						tex_total++;
				end else begin
					line_state = K_OTHER;
				end
			end
			K_FHEAD: begin
				if (c == CH_SPACE)
					line_state = K_FACE;
			end
			K_FACE: begin
				if (c == CH_SPACE) begin
					if (token_live)
						close_corner();
				end else if (c == CH_SLASH) begin
					token_live = 1'b1;
					finish_field();
				end else begin
					token_live = 1'b1;
					feed_digit(c);
				end
			end
			default: begin
			end
		endcase
		if (last) begin
			if (line_state == K_FACE && token_live)
				close_corner();
			finish_line();
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	function automatic void put_str(ref text_t line, input string s);
		for (int i = 0; i < s.len(); i++)
			line = {line, s[i]};
	endfunction

	function automatic void put_index(ref text_t line, input int cnt);
		int v;
		case ($urandom_range(0, 11)) inside
			[0:4]: v = (cnt > 0) ? int'($urandom_range(1, cnt)) : 1;
			[5:6]: v = (cnt > 0) ? -int'($urandom_range(1, cnt)) : -1;
			7: v = 0;
			8: v = cnt + 1;
			9: v = -(cnt + 1);
			default: v = int'($urandom_range(INDEX_LIMIT - 4, INDEX_LIMIT + 4));
		endcase
		if (v > 0 && $urandom_range(0, 4) == 0)
			put_str(line, "+");
		put_str(line, $sformatf("%0d", v));
		// long digit run saturates the magnitude
		if ($urandom_range(0, 15) == 0)
			put_str(line, "999999");
	endfunction

	function automatic void put_corner(ref text_t line);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: line = {line, CH_TAB};
				1: line = {line, CH_VTAB};
				2: line = {line, CH_FF};
				default: line = {line, CH_CR};
			endcase
		end
		case ($urandom_range(0, 9)) inside
			[0:1]: put_index(line, vert_total);
			[2:4]: begin
				put_index(line, vert_total);
				put_str(line, "/");
				put_index(line, tex_total);
			end
			5: begin
				put_index(line, vert_total);
				put_str(line, "//");
				put_index(line, vert_total);
			end
			6: begin
				put_index(line, vert_total);
				put_str(line, "/");
				put_index(line, tex_total);
				put_str(line, "/");
				put_index(line, vert_total);
			end
			7: begin
				put_index(line, vert_total);
				put_str(line, "/");
			end
			8: begin
				put_str(line, "/");
				put_index(line, tex_total);
			end
			default: begin
				put_index(line, vert_total);
				put_str(line, "x/3");
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (sender_idle && $urandom_range(0, 5) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.last_byte <= last;
		@(negedge clk);
		while (!text_ch.ready)
			@(negedge clk);
		@(posedge clk);
		parse_text_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_line(input text_t line, input bit close_last);
		for (int i = 0; i < line.size(); i++)
			send_byte(line[i], close_last && (i == line.size() - 1));
	endtask

	task automatic send_random_line();
		text_t line;
		int    kind_pick;
		int    ending;
		kind_pick = $urandom_range(0, 19);
		if (kind_pick < 4) begin
			if ($urandom_range(0, 1))
				put_str(line, "v 0.5 1 -2");
			else
				put_str(line, "v ");
		end else if (kind_pick < 6) begin
			if ($urandom_range(0, 1))
				put_str(line, "vt 0.25 1");
			else
				put_str(line, "vt");
		end else if (kind_pick < 15 || kind_pick >= 18) begin
			put_str(line, "f");
			if ($urandom_range(0, 5) == 0)
				put_str(line, "ace");
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 4) == 0)
					put_str(line, "  ");
				else
					put_str(line, " ");
				put_corner(line);
			end
			if ($urandom_range(0, 3) == 0)
				put_str(line, " ");
			// broken face line
			if (kind_pick >= 18)
				line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind_pick == 15) begin
			case ($urandom_range(0, 4))
				0: put_str(line, "# f 1 2 3");
				1: put_str(line, "vn 0 0 1");
				2: put_str(line, "v");
				3: put_str(line, " f 1 2 3");
				default: put_str(line, "f1 2 3 4");
			endcase
		end else begin
			repeat ($urandom_range(1, 12))
				line = {line, 8'($urandom_range(0, 255))};
		end
		ending = $urandom_range(0, 19);
		if (ending == 0) begin
			send_line(line, 1'b1);
		end else begin
			line = {line, CH_NL};
			send_line(line, ending == 1);
		end
	endtask

	task automatic test_directed_faces();
		text_t line;
		put_str(line, "v \nvt\nf 1/1 -1/ +1//1 ");
		line = {line, CH_CR};
		put_str(line, "-70000/2");
		send_line(line, 1'b1);
	endtask

	task automatic test_random_text();
		int stop_at;
		stop_at = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < stop_at)
			send_random_line();
	endtask

	task automatic test_output_stall();
		text_t line;
		sender_idle = 1'b0;
		hold_ticket <= hold_ticket + 1;
		put_str(line, "f");
		repeat (STALL_CORNERS) begin
			put_str(line, " ");
			put_corner(line);
		end
		line = {line, CH_NL};
		send_line(line, 1'b0);
		sender_idle = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			repeat ($urandom_range(1, 3))
				send_random_line();
			text_ch.valid <= 1'b0;
			while (triangles_due.size() != 0)
				@(posedge clk);
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	task automatic test_no_idle_tail();
		text_t fline;
		int    stop_at;
		sender_idle = 1'b0;
		receiver_idle <= 1'b0;
		stop_at = bytes_sent + TAIL_BYTES;
		while (bytes_sent < stop_at)
			send_random_line();
		put_str(fline, "f 65536/65536 -65536/-1 65537/-65537 0/0 99999999/65535 -65537/1");
		send_line(fline, 1'b1);
	endtask

	// receiver ready with random gaps and a long hold on request
	always @(posedge clk) begin
		if (hold_ticket != hold_served) begin
			hold_served <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			tri_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			tri_ch.ready <= 1'b0;
		end else if (ready_gap != 0) begin
			ready_gap <= ready_gap - 1;
			tri_ch.ready <= 1'b0;
		end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
			ready_gap <= $urandom_range(0, 3);
			tri_ch.ready <= 1'b0;
		end else begin
			tri_ch.ready <= 1'b1;
		end
	end

	// item is taken at the next rising edge when both are high here
	always @(negedge clk) begin : check_triangles
		tri_t want;
		if (arst_n && tri_ch.valid && tri_ch.ready) begin
			if (triangles_due.size() == 0) begin
				report_mismatch("triangle with nothing due", 1, 0);
			end else begin
				want = triangles_due.pop_front();
				if (tri_ch.pos_a !== want.pos_a)
					report_mismatch("pos_a", tri_ch.pos_a, want.pos_a);
				if (tri_ch.pos_b !== want.pos_b)
					report_mismatch("pos_b", tri_ch.pos_b, want.pos_b);
				if (tri_ch.pos_c !== want.pos_c)
					report_mismatch("pos_c", tri_ch.pos_c, want.pos_c);
				if (tri_ch.tex_a !== want.tex_a)
					report_mismatch("tex_a", tri_ch.tex_a, want.tex_a);
				if (tri_ch.tex_b !== want.tex_b)
					report_mismatch("tex_b", tri_ch.tex_b, want.tex_b);
				if (tri_ch.tex_c !== want.tex_c)
					report_mismatch("tex_c", tri_ch.tex_c, want.tex_c);
				if (tri_ch.tex_present !== want.tex_present)
					report_mismatch("tex_present", tri_ch.tex_present, want.tex_present);
				if (tri_ch.index_error !== want.index_error)
					report_mismatch("index_error", tri_ch.index_error, want.index_error);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("obj_face_index_triangulator_core_test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.last_byte = 1'b0;
		tri_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_faces();
		test_random_text();
		test_output_stall();
		test_drain_pause();
		test_no_idle_tail();

		text_ch.valid <= 1'b0;
		while (triangles_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && triangles_due.size() == 0)
			$display("obj_face_index_triangulator_core_test passed");
		else
			$display("obj_face_index_triangulator_core_test failed");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
rtl/ofit_pkg.sv
rtl/ofit_if.sv
rtl/ofit_front.sv
rtl/ofit_queue.sv
rtl/ofit_back.sv
rtl/obj_face_index_triangulator_core.sv
tb/obj_face_index_triangulator_core_test.sv
